// ===== rtl/sync_length_crc_frame_receiver_top_macros.svh =====
// Assertion macros shared by the frame receiver checker.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef SYNC_LENGTH_CRC_FRAME_RECEIVER_TOP_MACROS_SVH
`define SYNC_LENGTH_CRC_FRAME_RECEIVER_TOP_MACROS_SVH

// Clocked property, checked outside reset.
`define SLCFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, checked outside reset.
`define SLCFR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/slcfr_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the frame receiver.
// No dependencies.
`default_nettype none

package slcfr_pkg;

    // Sync pair and frame limits
    localparam logic [7:0]  SYNC_FIRST      = 8'h55;
    localparam logic [7:0]  SYNC_SECOND     = 8'hAA;
    localparam logic [15:0] SMALLEST_FRAME  = 16'd6;
    localparam logic [15:0] MAX_FRAME_BYTES = 16'd1024;
    localparam logic [10:0] MIN_LEN_RESET   = 11'd16;
    localparam logic [10:0] MAX_LEN_RESET   = 11'd1024;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    // APB register map
    localparam int unsigned APB_ADDR_W  = 3;
    localparam logic        REG_MIN_LEN = 1'b0;
    localparam logic        REG_MAX_LEN = 1'b1;

    // Receiver phase, one-hot
    typedef enum logic [4:0] {
        PH_HUNT1  = 5'b00001,
        PH_HUNT2  = 5'b00010,
        PH_LEN_LO = 5'b00100,
        PH_LEN_HI = 5'b01000,
        PH_BODY   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic [9:0]  byte_offset;
        logic [10:0] frame_length;
        logic        end_of_frame;
        logic        crc_good;
    } out_item_t;

    typedef struct packed {
        logic [10:0] min_len;
        logic [10:0] max_len;
    } cfg_t;

    // Modbus CRC-16, one byte, reflected
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // CRC state after the sync pair
    localparam logic [15:0] CRC_AFTER_SYNC =
        crc16_byte(crc16_byte(CRC_INIT, SYNC_FIRST), SYNC_SECOND);

endpackage

`default_nettype wire

// ===== rtl/slcfr_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// Payload type is set per instance; no other dependencies.
`default_nettype none

interface slcfr_stream_if #(parameter type payload_t = logic [7:0]) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/slcfr_apb_regs.sv =====
// APB configuration registers: minimum and maximum frame length.
// Depends on slcfr_pkg.
`default_nettype none

module slcfr_apb_regs
    import slcfr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [10:0] min_len_reg;
    logic [10:0] max_len_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Write the addressed register on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= MIN_LEN_RESET;
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_MIN_LEN: min_len_reg <= pwdata[10:0];
                REG_MAX_LEN: max_len_reg <= pwdata[10:0];
                default:     ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[2])
            REG_MIN_LEN: prdata = {21'd0, min_len_reg};
            REG_MAX_LEN: prdata = {21'd0, max_len_reg};
            default:     prdata = 32'd0;
        endcase
    end

    assign cfg.min_len = min_len_reg;
    assign cfg.max_len = max_len_reg;

endmodule

`default_nettype wire

// ===== rtl/slcfr_out_buf.sv =====
// Two-entry output buffer (output register plus skid stage) for result items.
// Depends on slcfr_pkg.
`default_nettype none

module slcfr_out_buf
    import slcfr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire out_item_t push_data,
    output logic           can_accept,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    logic      out_valid_reg;
    logic      skid_valid_reg;
    out_item_t out_data_reg;
    out_item_t skid_data_reg;
    logic      pop;

    assign pop        = out_valid_reg && out_ready;
    assign can_accept = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload: refill from skid, load new request, or park it in the skid
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_data_reg <= push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sync_length_crc_frame_receiver_top.sv =====
// Top level of the sync/length/CRC frame receiver.
// Depends on slcfr_pkg, slcfr_stream_if, slcfr_apb_regs and slcfr_out_buf.
//
//  channel | direction | payload                                         | handshake
//  rx      | in        | rx_byte                                         | valid/ready
//  frm     | out       | frame_byte, byte_offset, frame_length, eof, crc | valid/ready
//  apb     | in        | min/max frame length registers                  | psel/penable
//
// One received byte is taken per cycle while rx.ready is high; the phase, count
// and CRC registers update in the accepting cycle; body bytes go to frm via the buffer.
// The byte-wide CRC update is the deepest path between registers.
// A two-entry output buffer keeps rx ready while one result waits on frm;
// rx.ready drops only when both entries are full.
// rst_n clears the phase to sync hunting and the length registers to 16 and 1024.
`default_nettype none

module sync_length_crc_frame_receiver_top
    import slcfr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    slcfr_stream_if.sink               rx,
    slcfr_stream_if.source             frm,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    cfg_t        cfg;
    phase_t      phase_reg,    phase_next;
    logic [7:0]  len_lo_reg,   len_lo_next;
    logic [10:0] exp_len_reg,  exp_len_next;
    logic [10:0] count_reg,    count_next;
    logic [15:0] crc_reg,      crc_next;
    logic [7:0]  crc_lo_reg,   crc_lo_next;

    in_item_t    in_item;
    logic [7:0]  b;
    logic        accept;
    logic        buf_ready;
    logic        res_valid;
    out_item_t   res;
    logic [15:0] len16;
    logic        len_bad;
    logic [11:0] off_p2;
    logic [11:0] len12;

    slcfr_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_item  = rx.payload;
    assign b        = in_item.rx_byte;
    assign rx.ready = buf_ready;
    assign accept   = rx.valid && buf_ready;

    assign len16   = {b, len_lo_reg};
    assign len_bad = (len16 < {5'd0, cfg.min_len}) || (len16 > {5'd0, cfg.max_len})
                  || (len16 < SMALLEST_FRAME) || (len16 > MAX_FRAME_BYTES);
    assign off_p2  = {1'b0, count_reg} + 12'd2;
    assign len12   = {1'b0, exp_len_reg};

    // Phase decode and per-byte work
    always_comb
    begin
        phase_next   = phase_reg;
        len_lo_next  = len_lo_reg;
        exp_len_next = exp_len_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        crc_lo_next  = crc_lo_reg;
        res_valid    = 1'b0;
        res.frame_byte   = b;
        res.byte_offset  = count_reg[9:0];
        res.frame_length = exp_len_reg;
        res.end_of_frame = 1'b0;
        res.crc_good     = 1'b0;

        unique case (phase_reg)
            PH_HUNT1:
            begin
                if (b == SYNC_FIRST)
                begin
                    phase_next = PH_HUNT2;
                end
            end
            PH_HUNT2:
            begin
                if (b == SYNC_SECOND)
                begin
                    phase_next = PH_LEN_LO;
                end
                else if (b != SYNC_FIRST)
                begin
                    phase_next = PH_HUNT1;
                end
            end
            PH_LEN_LO:
            begin
                len_lo_next = b;
                crc_next    = crc16_byte(CRC_AFTER_SYNC, b);
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                if (len_bad)
                begin
                    // Drop the leading sync byte and rescan the held bytes
                    if (len_lo_reg == SYNC_FIRST && b == SYNC_SECOND)
                    begin
                        phase_next = PH_LEN_LO;
                    end
                    else if (b == SYNC_FIRST)
                    begin
                        phase_next = PH_HUNT2;
                    end
                    else
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                else
                begin
                    exp_len_next = len16[10:0];
                    crc_next     = crc16_byte(crc_reg, b);
                    count_next   = 11'd4;
                    phase_next   = PH_BODY;
                end
            end
            PH_BODY:
            begin
                res_valid = 1'b1;
                if (off_p2 < len12)
                begin
                    crc_next   = crc16_byte(crc_reg, b);
                    count_next = count_reg + 11'd1;
                end
                else if (off_p2 == len12)
                begin
                    crc_lo_next = b;
                    count_next  = count_reg + 11'd1;
                end
                else
                begin
                    // Last byte: compare received CRC, low byte first
                    res.end_of_frame = 1'b1;
                    res.crc_good     = ({b, crc_lo_reg} == crc_reg);
                    count_next       = 11'd0;
                    phase_next       = PH_HUNT1;
                end
            end
            default:
            begin
                phase_next = PH_HUNT1;
            end
        endcase
    end

    // Advance state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT1;
            len_lo_reg  <= 8'd0;
            exp_len_reg <= 11'd0;
            count_reg   <= 11'd0;
            crc_reg     <= CRC_INIT;
            crc_lo_reg  <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            len_lo_reg  <= len_lo_next;
            exp_len_reg <= exp_len_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            crc_lo_reg  <= crc_lo_next;
        end
    end

    slcfr_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept && res_valid),
        .push_data  (res),
        .can_accept (buf_ready),
        .out_valid  (frm.valid),
        .out_ready  (frm.ready),
        .out_data   (frm.payload)
    );

endmodule

`default_nettype wire

// ===== rtl/slcfr_checker.sv =====
// Port-level checker for the frame receiver, bound to the top level.
// Depends on slcfr_pkg and sync_length_crc_frame_receiver_top_macros.svh.
`default_nettype none
`include "sync_length_crc_frame_receiver_top_macros.svh"

module slcfr_checker
    import slcfr_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      frm_valid,
    input wire logic      frm_ready,
    input wire out_item_t frm_payload
);

    // Last byte sits one before the frame length
    `SLCFR_ASSERT_IMPL(a_eof_offset, frm_valid && frm_payload.end_of_frame, ({1'b0, frm_payload.byte_offset} + 11'd1) == frm_payload.frame_length, "end of frame at wrong offset")

    // CRC verdict only on the last byte
    `SLCFR_ASSERT_IMPL(a_crc_on_eof, frm_valid && frm_payload.crc_good, frm_payload.end_of_frame, "crc_good set before end of frame")

    // Body bytes start after the header and lie inside the frame
    `SLCFR_ASSERT_IMPL(a_offset_range, frm_valid, (frm_payload.byte_offset >= 10'd4) && ({1'b0, frm_payload.byte_offset} < frm_payload.frame_length), "byte offset out of frame")

    // Stalled request holds
    `SLCFR_ASSERT(a_stall_hold, frm_valid && !frm_ready |=> frm_valid && $stable(frm_payload), "stalled output request changed")

endmodule

bind sync_length_crc_frame_receiver_top slcfr_checker u_slcfr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .frm_valid   (frm.valid),
    .frm_ready   (frm.ready),
    .frm_payload (frm.payload)
);

`default_nettype wire

// ===== tb/sync_length_crc_frame_receiver_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the sync/length/CRC frame receiver top level.
// Depends on slcfr_pkg, slcfr_stream_if and sync_length_crc_frame_receiver_top;
// drives received bytes and length registers, predicts and checks every frame byte.

module sync_length_crc_frame_receiver_top_tb;
    import slcfr_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned IDLE_PERCENT = 26;
    localparam logic [APB_ADDR_W-1:0] MIN_LEN_ADDR = {REG_MIN_LEN, 2'b00};
    localparam logic [APB_ADDR_W-1:0] MAX_LEN_ADDR = {REG_MAX_LEN, 2'b00};
    localparam logic [10:0] DIR_FRAME_LEN = 11'd16;

    // One request of the directed list, with its result typed in where marked
    typedef struct {
        logic [7:0] rx_byte;
        bit         typed;
        bit         has_result;
        out_item_t  result;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    slcfr_stream_if #(.payload_t(in_item_t))  rx_if ();
    slcfr_stream_if #(.payload_t(out_item_t)) frm_if ();

    // Receiver state as the bench sees it
    phase_t      rx_phase;
    logic [7:0]  len_low_seen;
    logic [10:0] frame_len;
    int unsigned frame_pos;
    logic [15:0] crc_acc;
    logic [7:0]  crc_low_seen;
    logic [10:0] min_len_cfg;
    logic [10:0] max_len_cfg;

    out_item_t   frame_bytes_due[$];
    stim_row_t   directed_rows[$];
    stim_row_t   cur_row;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    int          errors = 0;
    bit          no_stall = 1'b0;

    sync_length_crc_frame_receiver_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_if),
        .frm     (frm_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Modbus CRC-16, shifted in one bit at a time, LSB first
    function automatic logic [15:0] modbus_crc_next(input logic [15:0] crc,
                                                    input logic [7:0]  data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ data[i];
            c  = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // Advance the receiver by one byte; returns 1 when a frame byte comes out
    function automatic bit predict_frame_byte(input logic [7:0] b, output out_item_t r);
        logic [15:0] len;
        r = '0;
        case (rx_phase)
            PH_HUNT1:
            begin
                if (b == SYNC_FIRST)
                    rx_phase = PH_HUNT2;
            end
            PH_HUNT2:
            begin
                if (b == SYNC_SECOND)
                    rx_phase = PH_LEN_LO;
                else if (b != SYNC_FIRST)
                    rx_phase = PH_HUNT1;
            end
            PH_LEN_LO:
            begin
                len_low_seen = b;
                rx_phase     = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len = {b, len_low_seen};
                if (len < min_len_cfg || len > max_len_cfg ||
                    len < SMALLEST_FRAME || len > MAX_FRAME_BYTES)
                begin
                    // drop the leading sync byte and rescan the held bytes
                    if (len_low_seen == SYNC_FIRST && b == SYNC_SECOND)
                        rx_phase = PH_LEN_LO;
                    else if (b == SYNC_FIRST)
                        rx_phase = PH_HUNT2;
                    else
                        rx_phase = PH_HUNT1;
                end
                else
                begin
                    frame_len = len[10:0];
                    crc_acc   = modbus_crc_next(modbus_crc_next(modbus_crc_next(
                                modbus_crc_next(CRC_INIT, SYNC_FIRST), SYNC_SECOND),
                                len_low_seen), b);
                    frame_pos = 4;
                    rx_phase  = PH_BODY;
                end
            end
            PH_BODY:
            begin
                r.frame_byte   = b;
                r.byte_offset  = frame_pos[9:0];
                r.frame_length = frame_len;
                if (frame_pos + 2 < frame_len)
                begin
                    crc_acc = modbus_crc_next(crc_acc, b);
                    frame_pos++;
                end
                else if (frame_pos + 2 == frame_len)
                begin
                    crc_low_seen = b;
                    frame_pos++;
                end
                else
                begin
                    // last byte: CRC arrives low byte first
                    r.end_of_frame = 1'b1;
                    r.crc_good     = ({b, crc_low_seen} == crc_acc);
                    rx_phase       = PH_HUNT1;
                    frame_pos      = 0;
                end
                return 1'b1;
            end
            default:
                rx_phase = PH_HUNT1;
        endcase
        return 1'b0;
    endfunction

    // Predict on each accepted request, check each accepted frame byte
    always @(posedge clk)
    begin : frame_checker
        out_item_t predicted;
        out_item_t want;
        bit        made;
        if (rst_n && rx_if.valid && rx_if.ready)
        begin
            made = predict_frame_byte(rx_if.payload.rx_byte, predicted);
            if (cur_row.typed)
            begin
                made      = cur_row.has_result;
                predicted = cur_row.result;
            end
            if (made)
                frame_bytes_due.push_back(predicted);
        end
        if (rst_n && frm_if.valid && frm_if.ready)
        begin
            if (frame_bytes_due.size() == 0)
            begin
                $display("%0t unexpected frame byte: byte %h offset %0d length %0d eof %b crc %b",
                         $time, frm_if.payload.frame_byte, frm_if.payload.byte_offset,
                         frm_if.payload.frame_length, frm_if.payload.end_of_frame,
                         frm_if.payload.crc_good);
                errors++;
            end
            else
            begin
                want = frame_bytes_due.pop_front();
                if (frm_if.payload.frame_byte !== want.frame_byte ||
                    frm_if.payload.byte_offset !== want.byte_offset ||
                    frm_if.payload.frame_length !== want.frame_length ||
                    frm_if.payload.end_of_frame !== want.end_of_frame ||
                    frm_if.payload.crc_good !== want.crc_good)
                begin
                    $display("%0t frame byte mismatch: expected byte %h offset %0d length %0d eof %b crc %b",
                             $time, want.frame_byte, want.byte_offset, want.frame_length,
                             want.end_of_frame, want.crc_good);
                    $display("%0t                       actual byte %h offset %0d length %0d eof %b crc %b",
                             $time, frm_if.payload.frame_byte, frm_if.payload.byte_offset,
                             frm_if.payload.frame_length, frm_if.payload.end_of_frame,
                             frm_if.payload.crc_good);
                    errors++;
                end
            end
        end
    end

    // Stall the frame output at random, unless a calm stretch is running
    always @(negedge clk)
        frm_if.ready <= no_stall || ($urandom_range(0, 99) >= IDLE_PERCENT);

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one request after a random gap; return at the falling edge after acceptance
    task automatic send_row(input stim_row_t row);
        while (!no_stall && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            rx_if.valid <= 1'b0;
            @(negedge clk);
        end
        cur_row = row;
        rx_if.valid           <= 1'b1;
        rx_if.payload.rx_byte <= row.rx_byte;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        stim_row_t row;
        row = '{rx_byte: b, typed: 1'b0, has_result: 1'b0, result: '0};
        send_row(row);
    endtask

    // Directed request with its result typed in; a negative offset means no result
    task automatic add_row(input logic [7:0] b, input int off);
        stim_row_t row;
        row.rx_byte    = b;
        row.typed      = 1'b1;
        row.has_result = (off >= 0);
        row.result     = '{frame_byte: b, byte_offset: off[9:0], frame_length: DIR_FRAME_LEN,
                           end_of_frame: 1'b0, crc_good: 1'b0};
        if (off < 0)
            row.result = '0;
        directed_rows.push_back(row);
    endtask

    // Send a whole frame with random body, optionally with a spoiled CRC or a leading sync byte
    task automatic send_frame(input logic [10:0] len, input bit crc_ok, input bit lead_sync);
        logic [7:0]  frame_data[$];
        logic [15:0] crc;
        frame_data.push_back(SYNC_FIRST);
        frame_data.push_back(SYNC_SECOND);
        frame_data.push_back(len[7:0]);
        frame_data.push_back({5'd0, len[10:8]});
        for (int i = 4; i < len - 2; i++)
            frame_data.push_back(8'($urandom_range(0, 255)));
        crc = CRC_INIT;
        foreach (frame_data[i])
            crc = modbus_crc_next(crc, frame_data[i]);
        if (!crc_ok)
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        frame_data.push_back(crc[7:0]);
        frame_data.push_back(crc[15:8]);
        if (lead_sync)
            send_byte(SYNC_FIRST);
        foreach (frame_data[i])
            send_byte(frame_data[i]);
    endtask

    // Sync pair followed by a length, out of range unless the fully random pick lands inside
    task automatic send_bad_length(input int unsigned lo_ok, input int unsigned hi_ok);
        logic [15:0] len;
        case ($urandom_range(0, 4))
            0:       len = 16'($urandom_range(0, lo_ok - 1));
            1:       len = 16'($urandom_range(hi_ok + 1, 16'hFFFF));
            2:       len = {SYNC_SECOND, SYNC_FIRST};
            3:       len = {SYNC_FIRST, 8'($urandom_range(0, 255))};
            default: len = 16'($urandom);
        endcase
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
    endtask

    // Mostly well-formed frames, the rest refused lengths and line noise
    task automatic run_random_phase(input int unsigned n_items);
        int unsigned start_count;
        int unsigned lo_ok;
        int unsigned hi_ok;
        int unsigned len;
        int unsigned pick;
        start_count = items_sent;
        lo_ok = (min_len_cfg > SMALLEST_FRAME) ? min_len_cfg : SMALLEST_FRAME;
        hi_ok = (max_len_cfg < MAX_FRAME_BYTES) ? max_len_cfg : MAX_FRAME_BYTES;
        while (items_sent - start_count < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70 && lo_ok <= hi_ok)
            begin
                repeat ($urandom_range(0, 2))
                    send_byte(8'($urandom_range(0, 255)));
                case ($urandom_range(0, 7))
                    0:       len = lo_ok;
                    1:       len = (hi_ok < lo_ok + 40) ? hi_ok : lo_ok + 40;
                    default: len = lo_ok + $urandom_range(0, (hi_ok - lo_ok < 16) ?
                                                          hi_ok - lo_ok : 16);
                endcase
                send_frame(len[10:0], $urandom_range(0, 4) != 0, $urandom_range(0, 4) == 0);
            end
            else if (pick < 85)
                send_bad_length(lo_ok, hi_ok);
            else
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Close any open frame with filler, then wait out every pending frame byte
    task automatic settle_receiver();
        while (rx_phase != PH_HUNT1)
            send_byte(8'h00);
        rx_if.valid <= 1'b0;
        while (frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Read a length register back and compare
    task automatic check_register(input logic [APB_ADDR_W-1:0] addr, input logic [10:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {21'd0, want})
        begin
            $display("%0t register read mismatch at %0d: expected %h actual %h",
                     $time, addr, {21'd0, want}, prdata);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_lengths(input logic [31:0] min_raw, input logic [31:0] max_raw);
        apb_write(MIN_LEN_ADDR, min_raw);
        apb_write(MAX_LEN_ADDR, max_raw);
        min_len_cfg = min_raw[10:0];
        max_len_cfg = max_raw[10:0];
        check_register(MIN_LEN_ADDR, min_len_cfg);
        check_register(MAX_LEN_ADDR, max_len_cfg);
    endtask

    initial
    begin
        logic [7:0]  body_bytes[10];
        logic [15:0] dir_crc;
        stim_row_t   last_row;

        // Hold reset with every input quiet
        rst_n                 = 1'b0;
        rx_if.valid           = 1'b0;
        rx_if.payload.rx_byte = 8'h00;
        frm_if.ready          = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = 32'd0;
        rx_phase              = PH_HUNT1;
        len_low_seen          = 8'h00;
        frame_len             = 11'd0;
        frame_pos             = 0;
        crc_acc               = CRC_INIT;
        crc_low_seen          = 8'h00;
        min_len_cfg           = MIN_LEN_RESET;
        max_len_cfg           = MAX_LEN_RESET;
        cur_row               = '{rx_byte: 8'h00, typed: 1'b0, has_result: 1'b0, result: '0};
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Registers come out of reset at 16 and 1024
        check_register(MIN_LEN_ADDR, MIN_LEN_RESET);
        check_register(MAX_LEN_ADDR, MAX_LEN_RESET);

        // Refused lengths and the rescans they trigger
        add_row(SYNC_FIRST, -1);
        add_row(SYNC_SECOND, -1);
        add_row(SYNC_FIRST, -1);
        add_row(SYNC_SECOND, -1);   // length bytes form a sync pair: read a new length
        add_row(8'hFF, -1);
        add_row(SYNC_FIRST, -1);    // high length byte starts a new sync
        add_row(SYNC_FIRST, -1);    // repeated first sync byte
        add_row(SYNC_SECOND, -1);
        add_row(8'h05, -1);
        add_row(8'h00, -1);         // below both minimums: back to hunting

        // Shortest frame at the reset minimum, body with byte extremes, good CRC
        add_row(SYNC_FIRST, -1);
        add_row(SYNC_SECOND, -1);
        add_row(8'h10, -1);
        add_row(8'h00, -1);
        body_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7E, 8'h81, 8'h33, 8'hCC};
        dir_crc = modbus_crc_next(modbus_crc_next(modbus_crc_next(
                  modbus_crc_next(CRC_INIT, SYNC_FIRST), SYNC_SECOND), 8'h10), 8'h00);
        foreach (body_bytes[i])
        begin
            add_row(body_bytes[i], 4 + i);
            dir_crc = modbus_crc_next(dir_crc, body_bytes[i]);
        end
        add_row(dir_crc[7:0], 14);
        last_row = '{rx_byte: dir_crc[15:8], typed: 1'b0, has_result: 1'b0, result: '0};
        directed_rows.push_back(last_row);

        foreach (directed_rows[i])
            send_row(directed_rows[i]);
        settle_receiver();

        // Narrow window 6..16, written with junk above bit 10
        set_lengths(32'hFFFF_F806, 32'h8000_0010);
        run_random_phase(150);
        settle_receiver();

        // Registers wide open: only the fixed limits of 6 and 1024 apply
        set_lengths(32'h0000_0000, 32'h0000_07FF);
        run_random_phase(150);
        settle_receiver();

        // Mid window with both sides running flat out
        no_stall = 1'b1;
        set_lengths(32'd20, 32'd40);
        run_random_phase(125);
        settle_receiver();
        no_stall = 1'b0;

        // Register values at the fixed limits of 6 and 1024, max written with junk above bit 10
        set_lengths(32'd6, 32'hFFFF_FC00);
        run_random_phase(125);
        settle_receiver();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/slcfr_pkg.sv
rtl/slcfr_stream_if.sv
rtl/slcfr_apb_regs.sv
rtl/slcfr_out_buf.sv
rtl/sync_length_crc_frame_receiver_top.sv
rtl/slcfr_checker.sv
tb/sync_length_crc_frame_receiver_top_tb.sv
